// File: src/pcc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the cksum block.
package pcc_pkg;

   localparam int unsigned DEFAULT_LENGTH_BITS = 40;
   localparam int unsigned OUT_LEN_BITS        = 40;
   localparam int unsigned CRC_BITS            = 32;
   localparam int unsigned BYTE_BITS           = 8;
   localparam int unsigned RSP_DATA_BITS       = CRC_BITS + OUT_LEN_BITS;

   localparam logic [CRC_BITS-1:0] CRC_POLY      = 32'h04C1_1DB7;
   localparam logic [CRC_BITS-1:0] XOR_OUT_RESET = 32'hFFFF_FFFF;

   typedef enum logic [0:0] {
      ST_RUN,
      ST_APPEND
   } state_type;

   typedef struct packed {
      logic take;
      logic load_len;
      logic shift;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic out_free;
   } status_type;

   function automatic logic [CRC_BITS-1:0] crc_byte(input logic [CRC_BITS-1:0] crc,
                                                    input logic [BYTE_BITS-1:0] data);
      logic [CRC_BITS-1:0] c;
      c = crc ^ {data, 24'h00_0000};
      for (int k = 0; k < BYTE_BITS; k++) begin
         if (c[CRC_BITS-1]) begin
            c = {c[CRC_BITS-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_BITS-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: src/pcc_ctrl.sv
// Controller: sequences message bytes, the length append and the result hand-off.
module pcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   output logic               req_tready,
   input  pcc_pkg::status_type status,
   output pcc_pkg::cmd_type    cmd
);
   import pcc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.take     = 1'b0;
      cmd.load_len = 1'b0;
      cmd.shift    = 1'b0;
      cmd.emit     = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (req_tlast) begin
                  cmd.load_len = 1'b1;
                  state_in     = ST_APPEND;
               end
            end
         end
         ST_APPEND: begin
            if (!status.len_zero) begin
               cmd.shift = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

endmodule

// File: src/pcc_dpath.sv
// Datapath: CRC register, byte counter, length shifter, mask and result register.
module pcc_dpath #(
   parameter int unsigned LENGTH_BITS = pcc_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcc_pkg::cmd_type                        cmd,
   output pcc_pkg::status_type                     status,
   input  logic [pcc_pkg::BYTE_BITS-1:0]           req_tdata,
   input  logic                                   req_tuser,
   input  logic                                   csr_we,
   input  logic [pcc_pkg::CRC_BITS-1:0]            csr_wdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [pcc_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                                   rsp_tuser
);
   import pcc_pkg::*;

   logic [CRC_BITS-1:0]      xor_out_ff;
   logic [CRC_BITS-1:0]      crc_ff;
   logic [CRC_BITS-1:0]      crc_in;
   logic [LENGTH_BITS-1:0]   count_ff;
   logic [LENGTH_BITS-1:0]   count_in;
   logic                     ovf_ff;
   logic                     ovf_in;
   logic [LENGTH_BITS-1:0]   len_ff;
   logic [LENGTH_BITS-1:0]   len_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                     rsp_user_ff;
   logic [63:0]              count_wide;
   logic [BYTE_BITS-1:0]     crc_data;
   logic [CRC_BITS-1:0]      crc_step;
   logic                     count_full;

   assign count_full = &count_ff;
   assign count_wide = 64'(count_ff);
   assign crc_data   = cmd.shift ? len_ff[BYTE_BITS-1:0] : req_tdata;
   assign crc_step   = crc_byte(crc_ff, crc_data);

   assign status.len_zero = (len_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      len_in   = len_ff;
      priority if (cmd.emit) begin
         crc_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.shift) begin
         crc_in = crc_step;
         len_in = len_ff >> BYTE_BITS;
      end else if (cmd.take) begin
         if (req_tuser) begin
            crc_in = crc_step;
            if (count_full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         if (cmd.load_len) begin
            len_in = count_in;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_out_ff   <= XOR_OUT_RESET;
         crc_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            xor_out_ff <= csr_wdata;
         end
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {count_wide[OUT_LEN_BITS-1:0], crc_ff ^ xor_out_ff};
         rsp_user_ff <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: src/posix_cksum_crc32.sv
// Top level of the POSIX cksum engine: controller plus datapath.
// Message bytes are taken one per cycle while req_tready is high; those with
// byte_valid set are folded into an MSB-first CRC-32 (polynomial 0x04C11DB7,
// start value zero) while a LENGTH_BITS-wide counter counts them (saturating,
// with too_long set when a byte arrives at the full count). The last transfer
// of a message is followed by the length append: each significant byte of the
// count is folded least significant first through the same byte-wide CRC unit,
// and then the result register is loaded once it is free; req_tready is low
// during the append. The result register waits for rsp_tready while the next
// message streams in. checksum is the CRC XORed with the csr mask (reset all
// ones); message_length carries the low 40 bits of the count.
module posix_cksum_crc32 #(
   parameter int unsigned LENGTH_BITS = pcc_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // data_byte
   input  logic                              req_tuser,   // byte_valid
   input  logic                              req_tlast,   // last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // checksum, message_length
   output logic                              rsp_tuser,   // too_long
   input  logic                              csr_we,
   input  logic [pcc_pkg::CRC_BITS-1:0]      csr_wdata    // xor_out
);
   import pcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcc_dpath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
